// File: hdl/cdeque_pkg.sv
// Shared types and constants for the circular deque.
package cdeque_pkg;

  localparam int unsigned DEPTH        = 128;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned ITEM_COUNT_W = 8;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } cdeque_act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdeque_status_e;

  // What every cell of a row does when the row updates
  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_SHIFT_IN  = 3'd1,  // take from the left neighbour, cell 0 takes the new value
    OP_SHIFT_OUT = 3'd2,  // take from the right neighbour
    OP_PUT_LAST  = 3'd3,  // first empty cell takes the new value
    OP_DROP_LAST = 3'd4   // last occupied cell empties
  } cdeque_op_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    cdeque_status_e           status;
    logic [ITEM_COUNT_W-1:0]  item_count;
  } cdeque_result_t;

endpackage

// File: hdl/cdeque_cell.sv
// One storage cell of a deque row: a data word and its valid flag.
module cdeque_cell
  import cdeque_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cdeque_op_e               op_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic                     left_valid_i,
  input  logic signed [DATA_W-1:0] left_data_i,
  input  logic                     right_valid_i,
  input  logic signed [DATA_W-1:0] right_data_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] data_o
);

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (op_i)
      OP_SHIFT_IN: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end
      OP_SHIFT_OUT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
      end
      OP_PUT_LAST: begin
        if (left_valid_i && !valid_q) begin
          valid_d = 1'b1;
          data_d  = push_value_i;
        end
      end
      OP_DROP_LAST: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
        data_d  = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/cdeque_row.sv
// A row of deque cells packed from cell 0, with its end entry at cell 0.
module cdeque_row
  import cdeque_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cdeque_op_e               op_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic signed [DATA_W-1:0] head_data_o
);

  logic [DEPTH-1:0]         valid;
  logic signed [DATA_W-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_valid, right_valid;
    logic signed [DATA_W-1:0] left_data, right_data;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_data  = push_value_i;
    end else begin : g_inner_l
      assign left_valid = valid[i-1];
      assign left_data  = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner_r
      assign right_valid = valid[i+1];
      assign right_data  = data[i+1];
    end

    cdeque_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op_i),
      .push_value_i (push_value_i),
      .left_valid_i (left_valid),
      .left_data_i  (left_data),
      .right_valid_i(right_valid),
      .right_data_i (right_data),
      .valid_o      (valid[i]),
      .data_o       (data[i])
    );
  end

  assign head_data_o = data[0];

endmodule

// File: hdl/circular_deque.sv
// Double-ended queue: top level with two mirrored cell rows and a result buffer.
//
// Input channel: in_valid_i, in_stall_o, action_i, push_value_i. A beat is taken
// at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o, out_stall_i, pop_value_o, status_o, item_count_o.
// Every input beat gives exactly one output beat, in order.
// Each result is registered into the result buffer; input beats are taken one
// per cycle while in_stall_o is low. Two rows of cells hold the entries, one in
// front-to-rear order and one in rear-to-front order; every cell updates from
// its neighbours in the same cycle, so both ends are at cell 0 of some row.
// Results wait in a two-entry buffer; in_stall_o rises only when it is full,
// so a stalled receiver blocks input after two beats and nothing is lost.
// Push when full reports overflow and changes nothing; pop when empty returns
// zero with underflow. item_count_o is the count after the action.
// Reset empties the deque and the result buffer; stored data is not cleared.
module circular_deque
  import cdeque_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic signed [DATA_W-1:0]       push_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [DATA_W-1:0]       pop_value_o,
  output logic [1:0]                     status_o,
  output logic [ITEM_COUNT_W-1:0]        item_count_o
);

  logic                     in_acc;
  logic [CNT_W-1:0]         occ_q, occ_d;
  logic                     full, empty;
  cdeque_op_e               front_op, rear_op;
  logic signed [DATA_W-1:0] front_head, rear_head;
  cdeque_result_t           res;

  logic [1:0]               buf_cnt_q, buf_cnt_d;
  cdeque_result_t           slot0_q, slot0_d, slot1_q, slot1_d;
  logic                     out_acc;

  assign in_stall_o = (buf_cnt_q == 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (occ_q == CNT_W'(DEPTH));
  assign empty      = (occ_q == '0);

  always_comb begin
    front_op      = OP_HOLD;
    rear_op       = OP_HOLD;
    occ_d         = occ_q;
    res.pop_value = '0;
    res.status    = ST_OK;
    case (cdeque_act_e'(action_i))
      ACT_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          front_op = OP_SHIFT_IN;
          rear_op  = OP_PUT_LAST;
          occ_d    = occ_q + 1'b1;
        end
      end
      ACT_PUSH_REAR: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          rear_op  = OP_SHIFT_IN;
          front_op = OP_PUT_LAST;
          occ_d    = occ_q + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          front_op      = OP_SHIFT_OUT;
          rear_op       = OP_DROP_LAST;
          occ_d         = occ_q - 1'b1;
          res.pop_value = front_head;
        end
      end
      ACT_POP_REAR: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          rear_op       = OP_SHIFT_OUT;
          front_op      = OP_DROP_LAST;
          occ_d         = occ_q - 1'b1;
          res.pop_value = rear_head;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.item_count = ITEM_COUNT_W'(occ_d);
    if (!in_acc) begin
      front_op = OP_HOLD;
      rear_op  = OP_HOLD;
      occ_d    = occ_q;
    end
  end

  cdeque_row u_front_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (front_op),
    .push_value_i(push_value_i),
    .head_data_o (front_head)
  );

  cdeque_row u_rear_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (rear_op),
    .push_value_i(push_value_i),
    .head_data_o (rear_head)
  );

  // Two-entry result buffer, slot 0 is the one on show
  assign out_acc = (buf_cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    buf_cnt_d = buf_cnt_q;
    if (out_acc) begin
      if (buf_cnt_q == 2'd2) begin
        slot0_d = slot1_q;
      end else if (in_acc) begin
        slot0_d = res;
      end
    end else if (in_acc) begin
      if (buf_cnt_q == 2'd0) begin
        slot0_d = res;
      end else begin
        slot1_d = res;
      end
    end
    case ({in_acc, out_acc})
      2'b10:   buf_cnt_d = buf_cnt_q + 2'd1;
      2'b01:   buf_cnt_d = buf_cnt_q - 2'd1;
      default: buf_cnt_d = buf_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      buf_cnt_q <= 2'd0;
    end else begin
      occ_q     <= occ_d;
      buf_cnt_q <= buf_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_valid_o  = (buf_cnt_q != 2'd0);
  assign pop_value_o  = slot0_q.pop_value;
  assign status_o     = slot0_q.status;
  assign item_count_o = slot0_q.item_count;

endmodule

// File: bench/circular_deque_checker.sv
// Beat monitor for the deque: predicts every result and compares it with the DUT.
`timescale 1ns / 100ps
module circular_deque_checker
  import cdeque_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] pop_value_i,
  input  logic [1:0]               status_i,
  input  logic [ITEM_COUNT_W-1:0]  item_count_i,
  output int                       mismatch_count_o,
  output int                       waiting_o
);

  logic signed [DATA_W-1:0] slot_q [DEPTH];
  int unsigned              head_q;
  int unsigned              tail_q;
  logic [31:0]              level_q;
  cdeque_result_t           pending_results [$];
  int                       fails;

  // Updates the shadow deque for one action and returns the result it gives.
  function automatic cdeque_result_t deque_apply(cdeque_act_e act,
                                                 logic signed [DATA_W-1:0] val);
    cdeque_result_t res;
    res.pop_value = '0;
    res.status    = ST_OK;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (level_q >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (act == ACT_PUSH_FRONT) begin
          head_q = (head_q == 0) ? DEPTH - 1 : head_q - 1;
          slot_q[head_q] = val;
          level_q = level_q + 1;
        end else begin
          slot_q[tail_q] = val;
          tail_q = (tail_q + 1 >= DEPTH) ? 0 : tail_q + 1;
          level_q = level_q + 1;
        end
      end
      default: begin
        if (level_q == 0) begin
          res.status = ST_UNDERFLOW;
        end else if (act == ACT_POP_FRONT) begin
          res.pop_value = slot_q[head_q];
          head_q = (head_q + 1 >= DEPTH) ? 0 : head_q + 1;
          level_q = level_q - 1;
        end else begin
          tail_q = (tail_q == 0) ? DEPTH - 1 : tail_q - 1;
          res.pop_value = slot_q[tail_q];
          level_q = level_q - 1;
        end
      end
    endcase
    res.item_count = level_q[ITEM_COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cdeque_result_t want;
    if (!rst_ni) begin
      head_q  = 0;
      tail_q  = 0;
      level_q = '0;
      fails   = 0;
      pending_results.delete();
      mismatch_count_o <= 0;
      waiting_o        <= 0;
    end else begin
      // result beats first; a result never leaves in the cycle its input is taken
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fails++;
          $error("result beat with no expectation waiting: pop_value %0d status %0d count %0d",
                 pop_value_i, status_i, item_count_i);
        end else begin
          want = pending_results.pop_front();
          if (pop_value_i !== want.pop_value) begin
            fails++;
            $error("pop_value: expected %0d, actual %0d", want.pop_value, pop_value_i);
          end
          if (status_i !== want.status) begin
            fails++;
            $error("status: expected %0d, actual %0d", want.status, status_i);
          end
          if (item_count_i !== want.item_count) begin
            fails++;
            $error("item_count: expected %0d, actual %0d", want.item_count, item_count_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(deque_apply(cdeque_act_e'(action_i), push_value_i));
      mismatch_count_o <= fails;
      waiting_o        <= pending_results.size();
    end
  end

endmodule

// File: bench/circular_deque_tb.sv
// Testbench top for the circular deque: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module circular_deque_tb
  import cdeque_pkg::*;
();

  localparam int CYCLE_LIMIT = 200_000;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               action_i     = ACT_PUSH_FRONT;
  logic signed [DATA_W-1:0] push_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic signed [DATA_W-1:0] pop_value_o;
  logic [1:0]               status_o;
  logic [ITEM_COUNT_W-1:0]  item_count_o;

  int mismatches;
  int waiting;
  int cycles = 0;
  bit calm   = 1'b0;

  circular_deque dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .item_count_o (item_count_o)
  );

  circular_deque_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .push_value_i     (push_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pop_value_i      (pop_value_o),
    .status_i         (status_o),
    .item_count_i     (item_count_o),
    .mismatch_count_o (mismatches),
    .waiting_o        (waiting)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 19);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one beat and returns once it is taken; valid is left high so that a
  // back-to-back beat needs no second assignment in the same step.
  task automatic send_beat(input cdeque_act_e act, input logic signed [DATA_W-1:0] val);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    push_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = '0;
        default: v = -1;
      endcase
    end
    return v;
  endfunction

  // push_pct sets the drift: high values run the deque into overflow, low into underflow
  task automatic run_phase(input int beats, input int push_pct);
    cdeque_act_e act;
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(99) < push_pct)
        act = $urandom_range(1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
      else
        act = $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
      send_beat(act, pick_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: underflow at both ends, extremes through both ends, order checks
    send_beat(ACT_POP_FRONT,  32'sh1234_5678);
    send_beat(ACT_POP_REAR,   -1);
    send_beat(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_beat(ACT_PUSH_REAR,  32'sh7fff_ffff);
    send_beat(ACT_PUSH_FRONT, '0);
    send_beat(ACT_PUSH_REAR,  -1);
    send_beat(ACT_PUSH_FRONT, 1);
    send_beat(ACT_POP_REAR,   '0);
    send_beat(ACT_POP_FRONT,  -1);
    send_beat(ACT_POP_FRONT,  '0);
    send_beat(ACT_POP_REAR,   '0);
    send_beat(ACT_POP_REAR,   '0);
    send_beat(ACT_POP_FRONT,  '0);
    send_beat(ACT_POP_REAR,   32'sh5555_5555);
    send_beat(ACT_PUSH_REAR,  32'shaaaa_aaaa);
    send_beat(ACT_POP_FRONT,  '0);
    send_beat(ACT_PUSH_FRONT, 32'sh5555_5555);
    send_beat(ACT_POP_REAR,   '0);
    send_beat(ACT_POP_FRONT,  '0);
    drain_results();

    run_phase(220, 88);
    run_phase(220, 12);
    drain_results();
    calm <= 1'b1;
    run_phase(150, 50);
    calm <= 1'b0;
    run_phase(180, 85);
    run_phase(150, 15);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && waiting == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
hdl/cdeque_pkg.sv
hdl/cdeque_cell.sv
hdl/cdeque_row.sv
hdl/circular_deque.sv
bench/circular_deque_checker.sv
bench/circular_deque_tb.sv
